>>> rtl/tccw_pkg.sv
// Shared types, constants and the command classifier of the text console writer.
package tccw_pkg;

	localparam int MAX_COLS_DEF = 256;
	localparam int MAX_ROWS_DEF = 64;
	localparam int QUEUE_DEPTH  = 2;

	localparam int COLS_REG_W   = 9;
	localparam int ROWS_REG_W   = 7;
	localparam int CFG_DATA_W   = 9;
	localparam int CURSOR_ROW_W = 6;
	localparam int CURSOR_COL_W = 8;

	localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd160;
	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd49;

	localparam logic [7:0] BLANK_GLYPH  = 8'd17;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_LINE_FEED = 8'd10;
	localparam logic [7:0] CH_CARR_RET  = 8'd13;
	localparam logic [7:0] CH_ASCII_LO  = 8'd32;
	localparam logic [7:0] CH_ASCII_HI  = 8'd127;
	localparam logic [7:0] ASCII_OFFSET = 8'd15;
	localparam logic [7:0] CH_HIGH_LO   = 8'd128;
	localparam logic [7:0] CH_HIGH_HI   = 8'd159;
	localparam logic [7:0] HIGH_OFFSET  = 8'd128;
	localparam logic [7:0] CH_EXT_LO    = 8'd160;
	localparam logic [7:0] CH_EXT_HI    = 8'd239;
	localparam logic [7:0] EXT_OFFSET   = 8'd48;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic {
		CFG_COLUMNS = 1'b0,
		CFG_ROWS    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PRINT,
		OP_BACKSPACE,
		OP_LINE_FEED,
		OP_CARRIAGE_RET,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_BLANK
	} state_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_byte;
		logic [5:0] read_row;
		logic [7:0] read_col;
	} item_t;

	typedef struct packed {
		logic [7:0] cell_glyph;
		logic [5:0] cursor_row;
		logic [7:0] cursor_col;
		logic       scrolled;
	} result_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] glyph;
		logic [5:0] read_row;
		logic [7:0] read_col;
	} entry_t;

	function automatic int eff_count(int v, int maxv);
		int r;
		r = v;
		if (v == 0) begin
			r = 1;
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	function automatic entry_t classify(item_t it);
		entry_t e;
		e.op       = OP_NOP;
		e.glyph    = it.char_byte;
		e.read_row = it.read_row;
		e.read_col = it.read_col;
		if (it.cmd == CMD_READ) begin
			e.op = OP_READ;
		end else if (it.char_byte >= CH_ASCII_LO && it.char_byte <= CH_ASCII_HI) begin
			e.op    = OP_PRINT;
			e.glyph = it.char_byte - ASCII_OFFSET;
		end else if (it.char_byte >= CH_HIGH_LO && it.char_byte <= CH_HIGH_HI) begin
			e.op    = OP_PRINT;
			e.glyph = it.char_byte - HIGH_OFFSET;
		end else if (it.char_byte >= CH_EXT_LO && it.char_byte <= CH_EXT_HI) begin
			e.op    = OP_PRINT;
			e.glyph = it.char_byte - EXT_OFFSET;
		end else if (it.char_byte == CH_BACKSPACE) begin
			e.op    = OP_BACKSPACE;
			e.glyph = BLANK_GLYPH;
		end else if (it.char_byte == CH_LINE_FEED) begin
			e.op = OP_LINE_FEED;
		end else if (it.char_byte == CH_CARR_RET) begin
			e.op = OP_CARRIAGE_RET;
		end
		return e;
	endfunction

endpackage

>>> rtl/text_console_char_writer.sv
// Top level of the text console character writer.
//
// Command channel: a transaction is taken at a clock edge with start high and
// busy low. cmd 0 puts char_byte at the cursor, cmd 1 reads the cell at
// read_row / read_col. Every transaction gives one result on result, shown for
// one cycle with done high; the receiver takes it then and cannot hold it off.
// A two-entry queue sits between the classifying front end and the back end,
// so up to two commands are taken while the back end is still working.
// A put without scroll is answered through the queue entry and the registered
// done and result; a read also passes ST_READ for the registered store read. A put
// that scrolls copies the window one cell per cycle through the store port pair.
// Sustained rate: one put per cycle unless one scrolls; a read stalls in ST_READ.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data, always ready;
// write only while no command is outstanding.
// Reset: cursor to 0,0, counts to 160 columns and 49 rows, then a clear sweep
// writes glyph 17 into all 2^clog2(MAX_ROWS) * 2^clog2(MAX_COLS) cells
// (16384 cells at default size) with busy held high.
module text_console_char_writer
	import tccw_pkg::*;
	#(
		parameter int MAX_COLS = MAX_COLS_DEF,
		parameter int MAX_ROWS = MAX_ROWS_DEF
	)
	(
		input  logic                  clk,
		input  logic                  arst_n,
		input  logic                  start,
		input  item_t                 item,
		output logic                  busy,
		output logic                  done,
		output result_t               result,
		input  logic                  cfg_valid,
		output logic                  cfg_ready,
		input  cfg_reg_t              cfg_index,
		input  logic [CFG_DATA_W-1:0] cfg_data
	);

	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int RCW = $clog2(MAX_ROWS + 1);

	logic [COLS_REG_W-1:0] cols_q;
	logic [ROWS_REG_W-1:0] rows_q;
	logic [CCW-1:0]        cols_eff;
	logic [RCW-1:0]        rows_eff;
	logic                  clearing;
	logic                  pop;
	logic                  head_valid;
	entry_t                head;

	assign cfg_ready = 1'b1;
	assign cols_eff  = CCW'(eff_count(int'(cols_q), MAX_COLS));
	assign rows_eff  = RCW'(eff_count(int'(rows_q), MAX_ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLUMNS: cols_q <= cfg_data[COLS_REG_W-1:0];
				CFG_ROWS:    rows_q <= cfg_data[ROWS_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tccw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.clearing   (clearing),
		.busy       (busy),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tccw_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cols_eff   (cols_eff),
		.rows_eff   (rows_eff),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.done       (done),
		.result     (result)
	);

	a_no_result_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) clearing |-> !done
	) else $error("result issued during clear sweep");

	a_scroll_cursor: assert property (
		@(posedge clk) disable iff (!arst_n)
		(done && result.scrolled) |->
			(result.cursor_col == '0 && int'(result.cursor_row) == int'(rows_eff) - 1)
	) else $error("scroll left the cursor off the start of the last row");

	a_clear_blocks_input: assert property (
		@(posedge clk) disable iff (!arst_n) $rose(clearing) |-> !pop
	) else $error("command taken from queue during clear sweep");

endmodule

>>> rtl/tccw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tccw_ram
	#(
		parameter int WIDTH = 8,
		parameter int DEPTH = 16384
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tccw_front.sv
// Command front end: classifies accepted transactions and queues them for the back end.
module tccw_front
	import tccw_pkg::*;
	(
		input  logic   clk,
		input  logic   arst_n,
		input  logic   start,
		input  item_t  item,
		input  logic   clearing,
		output logic   busy,
		input  logic   pop,
		output logic   head_valid,
		output entry_t head
	);

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	entry_t           entries_q [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             full;
	logic             push;

	assign full       = (count_q == QCW'(QUEUE_DEPTH));
	assign busy       = full || clearing;
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= classify(item);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/tccw_back.sv
// Command back end: cursor, cell store access, scrolling and the start-up clear sweep.
module tccw_back
	import tccw_pkg::*;
	#(
		parameter int MAX_COLS = MAX_COLS_DEF,
		parameter int MAX_ROWS = MAX_ROWS_DEF
	)
	(
		input  logic                          clk,
		input  logic                          arst_n,
		input  logic [$clog2(MAX_COLS+1)-1:0] cols_eff,
		input  logic [$clog2(MAX_ROWS+1)-1:0] rows_eff,
		input  logic                          head_valid,
		input  entry_t                        head,
		output logic                          pop,
		output logic                          clearing,
		output logic                          done,
		output result_t                       result
	);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = (2 ** RW) * (2 ** CW);
	localparam int CCW   = $clog2(MAX_COLS + 1);
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS - 1);

	state_t          state_q;
	state_t          state_d;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   scan_row_q;
	logic [CW-1:0]   scan_col_q;
	logic [AW-1:0]   clr_addr_q;
	logic            pend_s1;
	logic [AW-1:0]   pend_addr_s1;
	logic            oor_q;
	logic            done_q;
	result_t         result_q;

	logic [RCW-1:0]  r0;
	logic [RCW-1:0]  r1;
	logic [CCW-1:0]  c0;
	logic [CCW-1:0]  c1;
	logic            scroll;
	logic            wr_put;
	logic [CW-1:0]   put_col;
	logic [RW-1:0]   last_row;
	logic            in_window;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [7:0]      wdata;
	logic [AW-1:0]   raddr;
	logic [7:0]      rdata;

	assign last_row  = RW'(rows_eff - 1'b1);
	assign in_window = (int'(head.read_row) < int'(rows_eff)) &&
	                   (int'(head.read_col) < int'(cols_eff));

	always_comb begin
		r0      = (RCW'(row_q) >= rows_eff) ? rows_eff - 1'b1 : RCW'(row_q);
		c0      = (CCW'(col_q) >= cols_eff) ? cols_eff - 1'b1 : CCW'(col_q);
		r1      = r0;
		c1      = c0;
		wr_put  = 1'b0;
		put_col = c0[CW-1:0];
		unique case (head.op)
			OP_PRINT: begin
				wr_put = 1'b1;
				c1     = c0 + 1'b1;
			end
			OP_BACKSPACE: begin
				wr_put = 1'b1;
				if (c0 != '0) begin
					c1 = c0 - 1'b1;
				end
				put_col = c1[CW-1:0];
			end
			OP_LINE_FEED: begin
				c1 = '0;
				r1 = r0 + 1'b1;
			end
			OP_CARRIAGE_RET: begin
				c1 = '0;
			end
			default: begin
			end
		endcase
		if (c1 >= cols_eff) begin
			c1 = '0;
			r1 = r1 + 1'b1;
		end
		scroll = (r1 >= rows_eff);
		if (scroll) begin
			r1 = rows_eff - 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					priority if (head.op == OP_READ) begin
						state_d = ST_READ;
					end else if (scroll) begin
						state_d = (rows_eff > RCW'(1)) ? ST_COPY : ST_BLANK;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_COPY: begin
				if (scan_col_q == COL_LAST && scan_row_q == last_row) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				if (!pend_s1 && scan_col_q == COL_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		pop      = (state_q == ST_IDLE) && head_valid;
		clearing = (state_q == ST_CLEAR);
		raddr    = (state_q == ST_COPY) ? {scan_row_q, scan_col_q}
		                                : {head.read_row[RW-1:0], head.read_col[CW-1:0]};
		we       = 1'b0;
		waddr    = {r0[RW-1:0], put_col};
		wdata    = head.glyph;
		priority if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = BLANK_GLYPH;
		end else if (pend_s1) begin
			we    = 1'b1;
			waddr = pend_addr_s1;
			wdata = rdata;
		end else if (state_q == ST_BLANK) begin
			we    = 1'b1;
			waddr = {last_row, scan_col_q};
			wdata = BLANK_GLYPH;
		end else if (pop && wr_put) begin
			we = 1'b1;
		end else begin
			we = 1'b0;
		end
	end

	tccw_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			row_q      <= '0;
			col_q      <= '0;
			scan_row_q <= '0;
			scan_col_q <= '0;
			clr_addr_q <= '0;
			pend_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_COPY);
			done_q  <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (pop && head.op != OP_READ) begin
						row_q <= r1[RW-1:0];
						col_q <= c1[CW-1:0];
						if (scroll) begin
							scan_row_q <= RW'(1);
							scan_col_q <= '0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					done_q <= 1'b1;
				end
				ST_COPY: begin
					if (scan_col_q == COL_LAST) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + 1'b1;
					end else begin
						scan_col_q <= scan_col_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (!pend_s1) begin
						scan_col_q <= (scan_col_q == COL_LAST) ? '0 : scan_col_q + 1'b1;
						if (scan_col_q == COL_LAST) begin
							done_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= {scan_row_q - 1'b1, scan_col_q};
		if (pop && head.op == OP_READ) begin
			oor_q <= !in_window;
		end
		priority if (state_q == ST_READ) begin
			result_q.cell_glyph <= oor_q ? BLANK_GLYPH : rdata;
			result_q.cursor_row <= CURSOR_ROW_W'(row_q);
			result_q.cursor_col <= CURSOR_COL_W'(col_q);
			result_q.scrolled   <= 1'b0;
		end else if (pop && head.op != OP_READ && !scroll) begin
			result_q.cell_glyph <= '0;
			result_q.cursor_row <= CURSOR_ROW_W'(r1[RW-1:0]);
			result_q.cursor_col <= CURSOR_COL_W'(c1[CW-1:0]);
			result_q.scrolled   <= 1'b0;
		end else if (state_q == ST_BLANK && !pend_s1 && scan_col_q == COL_LAST) begin
			result_q.cell_glyph <= '0;
			result_q.cursor_row <= CURSOR_ROW_W'(row_q);
			result_q.cursor_col <= CURSOR_COL_W'(col_q);
			result_q.scrolled   <= 1'b1;
		end else begin
			result_q <= result_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
